>>> hw/rtl/gtbm_pkg.sv
// Shared constants and types for the group top/bottom mean unit.
package gtbm_pkg;

  localparam int MAX_GROUP = 64;
  localparam int SCORE_W   = 32;
  localparam int CFG_W     = 7;
  localparam int COUNT_W   = 7;

  localparam logic [CFG_W-1:0] MIN_GROUP_RESET = 7'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_END,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } gtbm_state_t;

endpackage

>>> hw/rtl/gtbm_if.sv
// Request and result channel interfaces for the group top/bottom mean unit.
interface gtbm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gtbm_pkg::SCORE_W-1:0]  score;
  logic                                 last_in_group;

  modport source (output valid, output score, output last_in_group, input ready);
  modport sink   (input valid, input score, input last_in_group, output ready);
endinterface

interface gtbm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gtbm_pkg::SCORE_W-1:0]  top_mean;
  logic signed [gtbm_pkg::SCORE_W-1:0]  bottom_mean;
  logic                                 group_valid;
  logic        [gtbm_pkg::COUNT_W-1:0]  member_count;
  logic                                 overflowed;

  modport source (output valid, output top_mean, output bottom_mean, output group_valid,
                  output member_count, output overflowed, input ready);
  modport sink   (input valid, input top_mean, input bottom_mean, input group_valid,
                  input member_count, input overflowed, output ready);
endinterface

>>> hw/rtl/group_top_bottom_mean.sv
// Top level of the group top/bottom mean unit.
// Scores are kept in ascending order in a single-port-read score memory: each accepted score
// is insertion-sorted into place, each held score greater than it moving up one entry,
// before the next request is taken, one memory read and write per cycle. At the end of a
// valid group of n scores the unit sweeps the memory once, then runs a one-bit-per-cycle
// restoring divider twice for the rounded means, with a check state before the sweep and an
// output state at the end. An invalid group skips the sweep and the divisions. A finished
// result waits in an output register while the next group's scores are taken. The memory
// needs no clearing after reset.
module group_top_bottom_mean #(
  parameter int MAX_GROUP = gtbm_pkg::MAX_GROUP
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gtbm_in_if.sink                        in_ch,
  gtbm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [gtbm_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int CW  = $clog2(MAX_GROUP + 1);
  localparam int AW  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int SW  = gtbm_pkg::SCORE_W + CW;
  localparam int DCW = $clog2(SW + 1);
  localparam int VW  = (CW > gtbm_pkg::CFG_W) ? CW : gtbm_pkg::CFG_W;
  localparam int XW  = gtbm_pkg::SCORE_W;

  gtbm_pkg::gtbm_state_t state_r, state_nxt;

  logic [gtbm_pkg::CFG_W-1:0] min_r, min_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CW-1:0]        kq_r, kq_nxt;
  logic [1:0]           kr_r, kr_nxt;
  logic signed [XW-1:0] v_r, v_nxt;
  logic [CW-1:0]        j_r, j_nxt;
  logic                 last_r, last_nxt;
  logic [CW-1:0]        sidx_r, sidx_nxt;
  logic                 pv_r, pv_nxt;
  logic [CW-1:0]        pidx_r, pidx_nxt;
  logic signed [SW-1:0] lo_r, lo_nxt;
  logic signed [SW-1:0] hi_r, hi_nxt;
  logic [SW-1:0]        dq_r, dq_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [DCW-1:0]       dcnt_r, dcnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 dsel_r, dsel_nxt;
  logic [XW-1:0]        top_res_r, top_res_nxt;
  logic [XW-1:0]        bot_res_r, bot_res_nxt;

  logic                 ov_r, ov_nxt;
  logic [XW-1:0]        otop_r, otop_nxt;
  logic [XW-1:0]        obot_r, obot_nxt;
  logic                 ogv_r, ogv_nxt;
  logic [gtbm_pkg::COUNT_W-1:0] omc_r, omc_nxt;
  logic                 oof_r, oof_nxt;
  logic                 gv_r, gv_nxt;

  // score memory
  logic [XW-1:0] mem [MAX_GROUP];
  logic [XW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [XW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic                 accept;
  logic signed [SW-1:0] ld_sum;
  logic                 ld_neg;
  logic [SW-1:0]        ld_mag;
  logic [CW:0]          div_t;
  logic                 div_ge;
  logic [SW-1:0]        q_signed;
  logic signed [SW-1:0] rd_ext;
  logic [CW-1:0]        nk;
  logic [CW-1:0]        jm1, jm2;

  assign in_ch.ready         = (state_r == gtbm_pkg::ST_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = ov_r;
  assign out_ch.top_mean     = otop_r;
  assign out_ch.bottom_mean  = obot_r;
  assign out_ch.group_valid  = ogv_r;
  assign out_ch.member_count = omc_r;
  assign out_ch.overflowed   = oof_r;

  assign ld_sum   = (state_r == gtbm_pkg::ST_SUM) ? hi_r : lo_r;
  assign ld_neg   = ld_sum[SW-1];
  assign ld_mag   = (ld_neg ? SW'(-ld_sum) : SW'(ld_sum)) + SW'(kq_r >> 1);
  assign div_t    = {rem_r, dq_r[SW-1]};
  assign div_ge   = div_t >= {1'b0, kq_r};
  assign q_signed = neg_r ? SW'(-dq_r) : dq_r;
  assign rd_ext   = SW'($signed(rdata_r));
  assign nk       = cnt_r - kq_r;
  assign jm1      = cnt_r - CW'(1);
  assign jm2      = j_r - CW'(2);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt   = state_r;
    min_nxt     = cfg_we ? cfg_wdata : min_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    kq_nxt      = kq_r;
    kr_nxt      = kr_r;
    v_nxt       = v_r;
    j_nxt       = j_r;
    last_nxt    = last_r;
    sidx_nxt    = sidx_r;
    pv_nxt      = 1'b0;
    pidx_nxt    = pidx_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    dq_nxt      = dq_r;
    rem_nxt     = rem_r;
    dcnt_nxt    = dcnt_r;
    neg_nxt     = neg_r;
    dsel_nxt    = dsel_r;
    top_res_nxt = top_res_r;
    bot_res_nxt = bot_res_r;
    gv_nxt      = gv_r;
    ov_nxt      = ov_r && !out_ch.ready;
    otop_nxt    = otop_r;
    obot_nxt    = obot_r;
    ogv_nxt     = ogv_r;
    omc_nxt     = omc_r;
    oof_nxt     = oof_r;
    mem_we      = 1'b0;
    mem_waddr   = j_r[AW-1:0];
    mem_wdata   = rdata_r;
    mem_raddr   = jm2[AW-1:0];

    unique case (state_r)
      gtbm_pkg::ST_IDLE: begin
        mem_raddr = jm1[AW-1:0];
        if (accept) begin
          last_nxt = in_ch.last_in_group;
          if (cnt_r != CW'(MAX_GROUP)) begin
            v_nxt     = in_ch.score;
            j_nxt     = cnt_r;
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = gtbm_pkg::ST_SHIFT;
            if (kr_r == 2'd0) begin
              kr_nxt = 2'd2;
            end else begin
              kr_nxt = kr_r - 2'd1;
              kq_nxt = kq_r + CW'(1);
            end
          end else begin
            // store full: drop the score
            ovf_nxt = 1'b1;
            if (in_ch.last_in_group) begin
              state_nxt = gtbm_pkg::ST_END;
            end
          end
        end
      end

      gtbm_pkg::ST_SHIFT: begin
        mem_we = 1'b1;
        if (j_r != '0 && $signed(rdata_r) > v_r) begin
          j_nxt = j_r - CW'(1);
        end else begin
          mem_wdata = v_r;
          state_nxt = last_r ? gtbm_pkg::ST_END : gtbm_pkg::ST_IDLE;
        end
      end

      gtbm_pkg::ST_END: begin
        gv_nxt = VW'(cnt_r) >= VW'(min_r);
        if (VW'(cnt_r) >= VW'(min_r)) begin
          sidx_nxt  = '0;
          lo_nxt    = '0;
          hi_nxt    = '0;
          state_nxt = gtbm_pkg::ST_SUM;
        end else begin
          top_res_nxt = '0;
          bot_res_nxt = '0;
          state_nxt   = gtbm_pkg::ST_OUT;
        end
      end

      gtbm_pkg::ST_SUM: begin
        mem_raddr = sidx_r[AW-1:0];
        if (sidx_r != cnt_r) begin
          pv_nxt   = 1'b1;
          pidx_nxt = sidx_r;
          sidx_nxt = sidx_r + CW'(1);
        end
        if (pv_r) begin
          if (pidx_r < kq_r) begin
            lo_nxt = lo_r + rd_ext;
          end
          if (pidx_r >= nk) begin
            hi_nxt = hi_r + rd_ext;
          end
        end else if (sidx_r == cnt_r) begin
          // start the top mean division
          dq_nxt    = ld_mag;
          neg_nxt   = ld_neg;
          rem_nxt   = '0;
          dcnt_nxt  = DCW'(SW);
          dsel_nxt  = 1'b0;
          state_nxt = gtbm_pkg::ST_DIV;
        end
      end

      gtbm_pkg::ST_DIV: begin
        if (dcnt_r != '0) begin
          rem_nxt  = div_ge ? CW'(div_t - {1'b0, kq_r}) : div_t[CW-1:0];
          dq_nxt   = {dq_r[SW-2:0], div_ge};
          dcnt_nxt = dcnt_r - DCW'(1);
        end else if (!dsel_r) begin
          top_res_nxt = q_signed[XW-1:0];
          dq_nxt      = ld_mag;
          neg_nxt     = ld_neg;
          rem_nxt     = '0;
          dcnt_nxt    = DCW'(SW);
          dsel_nxt    = 1'b1;
        end else begin
          bot_res_nxt = q_signed[XW-1:0];
          state_nxt   = gtbm_pkg::ST_OUT;
        end
      end

      gtbm_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          otop_nxt  = top_res_r;
          obot_nxt  = bot_res_r;
          ogv_nxt   = gv_r;
          omc_nxt   = gtbm_pkg::COUNT_W'(cnt_r);
          oof_nxt   = ovf_r;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          kq_nxt    = '0;
          kr_nxt    = 2'd2;
          state_nxt = gtbm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = gtbm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtbm_pkg::ST_IDLE;
      min_r   <= gtbm_pkg::MIN_GROUP_RESET;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      kq_r    <= '0;
      kr_r    <= 2'd2;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      min_r   <= min_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      kq_r    <= kq_nxt;
      kr_r    <= kr_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    j_r       <= j_nxt;
    last_r    <= last_nxt;
    sidx_r    <= sidx_nxt;
    pidx_r    <= pidx_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    dcnt_r    <= dcnt_nxt;
    neg_r     <= neg_nxt;
    dsel_r    <= dsel_nxt;
    top_res_r <= top_res_nxt;
    bot_res_r <= bot_res_nxt;
    gv_r      <= gv_nxt;
    otop_r    <= otop_nxt;
    obot_r    <= obot_nxt;
    ogv_r     <= ogv_nxt;
    omc_r     <= omc_nxt;
    oof_r     <= oof_nxt;
  end

endmodule

>>> hw/rtl/gtbm_checker.sv
// Port-level assertions for the group top/bottom mean unit, and their bind.
module gtbm_checker #(
  parameter int MAX_GROUP = gtbm_pkg::MAX_GROUP
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [gtbm_pkg::SCORE_W-1:0]  top_mean,
  input logic signed [gtbm_pkg::SCORE_W-1:0]  bottom_mean,
  input logic                                 group_valid,
  input logic        [gtbm_pkg::COUNT_W-1:0]  member_count,
  input logic                                 overflowed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(top_mean) && $stable(bottom_mean))
    else $error("result dropped or changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !group_valid |-> top_mean == '0 && bottom_mean == '0)
    else $error("invalid group with nonzero means");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && group_valid |-> top_mean >= bottom_mean)
    else $error("top mean below bottom mean");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflowed |-> member_count == gtbm_pkg::COUNT_W'(MAX_GROUP))
    else $error("overflow flagged with store not full");

endmodule

bind group_top_bottom_mean gtbm_checker #(.MAX_GROUP(MAX_GROUP)) u_gtbm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .top_mean     (out_ch.top_mean),
  .bottom_mean  (out_ch.bottom_mean),
  .group_valid  (out_ch.group_valid),
  .member_count (out_ch.member_count),
  .overflowed   (out_ch.overflowed)
);
